[rtl/avgpb_pkg.sv]
package avgpb_pkg;

  localparam int OUT_H  = 64;
  localparam int OUT_W  = 64;
  localparam int DEPTH  = OUT_H * OUT_W;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = $clog2(OUT_H);
  localparam int COL_W  = $clog2(OUT_W);
  localparam int CLIP_W = $clog2((OUT_H > OUT_W ? OUT_H : OUT_W) + 1);
  localparam int DATA_W = 32;
  localparam int AREA_W = 10;
  localparam int DCNT_W = $clog2(DATA_W);
  localparam int POS_W  = 15;
  localparam int PADDR_W = 5;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_CLEAR   = 2'd0;
  localparam opcode_t OP_SCATTER = 2'd1;
  localparam opcode_t OP_READ    = 2'd2;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_KH   = 3'd0;
  localparam reg_idx_t REG_KW   = 3'd1;
  localparam reg_idx_t REG_SR   = 3'd2;
  localparam reg_idx_t REG_SC   = 3'd3;
  localparam reg_idx_t REG_PT   = 3'd4;
  localparam reg_idx_t REG_PL   = 3'd5;
  localparam reg_idx_t REG_INCL = 3'd6;

  typedef struct packed {
    logic [4:0] kernel_height;
    logic [4:0] kernel_width;
    logic [4:0] stride_rows;
    logic [4:0] stride_cols;
    logic [3:0] padding_top;
    logic [3:0] padding_left;
    logic       include_padding;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_WIN, ST_AREA, ST_DIV, ST_QUOT, ST_CELL_RD, ST_CELL_WR, ST_READ
  } state_t;

  typedef struct packed {
    logic ld_item;
    logic rd_item;
    logic win;
    logic area;
    logic div_step;
    logic quot;
    logic cell_rd;
    logic cell_wr;
    logic out_load;
    logic clr_wr;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic div_last;
    logic cell_last;
    logic clr_last;
    logic out_free;
  } stat_t;

endpackage

[rtl/avgpb_if.sv]
interface avgpb_item_if;
  import avgpb_pkg::*;
  logic                     valid;
  logic                     ready;
  opcode_t                  opcode;
  logic signed [DATA_W-1:0] grad_value;
  logic [7:0]               pooled_row;
  logic [7:0]               pooled_col;
  logic [5:0]               read_row;
  logic [5:0]               read_col;
  modport source (output valid, opcode, grad_value, pooled_row, pooled_col, read_row,
                  read_col, input ready);
  modport sink (input valid, opcode, grad_value, pooled_row, pooled_col, read_row,
                read_col, output ready);
endinterface

interface avgpb_result_if;
  import avgpb_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  modport source (output valid, read_value, input ready);
  modport sink (input valid, read_value, output ready);
endinterface

[rtl/avgpb_regs.sv]
module avgpb_regs
  import avgpb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kernel_height   <= 5'd2;
      cfg.kernel_width    <= 5'd2;
      cfg.stride_rows     <= 5'd2;
      cfg.stride_cols     <= 5'd2;
      cfg.padding_top     <= 4'd0;
      cfg.padding_left    <= 4'd0;
      cfg.include_padding <= 1'b1;
    end else if (wr) begin
      unique case (idx)
        REG_KH:   cfg.kernel_height   <= pwdata[4:0];
        REG_KW:   cfg.kernel_width    <= pwdata[4:0];
        REG_SR:   cfg.stride_rows     <= pwdata[4:0];
        REG_SC:   cfg.stride_cols     <= pwdata[4:0];
        REG_PT:   cfg.padding_top     <= pwdata[3:0];
        REG_PL:   cfg.padding_left    <= pwdata[3:0];
        REG_INCL: cfg.include_padding <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_KH:   prdata = {27'd0, cfg.kernel_height};
      REG_KW:   prdata = {27'd0, cfg.kernel_width};
      REG_SR:   prdata = {27'd0, cfg.stride_rows};
      REG_SC:   prdata = {27'd0, cfg.stride_cols};
      REG_PT:   prdata = {28'd0, cfg.padding_top};
      REG_PL:   prdata = {28'd0, cfg.padding_left};
      REG_INCL: prdata = {31'd0, cfg.include_padding};
      default:  prdata = '0;
    endcase
  end

endmodule

[rtl/avgpb_ctrl.sv]
module avgpb_ctrl
  import avgpb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  opcode_t item_opcode,
  output logic    item_ready,
  input  stat_t   stat,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    accept     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        // a read needs the result register free by the time its data lands
        item_ready = stat.out_free || (item_opcode != OP_READ);
        accept     = item_valid && item_ready;
        if (accept) begin
          unique case (item_opcode)
            OP_CLEAR: state_next = ST_CLEAR;
            OP_SCATTER: begin
              cmd.ld_item = 1'b1;
              state_next  = ST_WIN;
            end
            OP_READ: begin
              cmd.rd_item = 1'b1;
              state_next  = ST_READ;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_WIN: begin
        cmd.win    = 1'b1;
        state_next = ST_AREA;
      end
      ST_AREA: begin
        cmd.area   = 1'b1;
        state_next = stat.empty ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = ST_QUOT;
      end
      ST_QUOT: begin
        cmd.quot   = 1'b1;
        state_next = ST_CELL_RD;
      end
      ST_CELL_RD: begin
        cmd.cell_rd = 1'b1;
        state_next  = ST_CELL_WR;
      end
      ST_CELL_WR: begin
        cmd.cell_wr = 1'b1;
        state_next  = stat.cell_last ? ST_IDLE : ST_CELL_RD;
      end
      ST_READ: begin
        cmd.out_load = 1'b1;
        state_next   = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[rtl/avgpb_dp.sv]
module avgpb_dp
  import avgpb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  input  logic signed [DATA_W-1:0] grad_value,
  input  logic [7:0]               pooled_row,
  input  logic [7:0]               pooled_col,
  input  logic [5:0]               read_row,
  input  logic [5:0]               read_col,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_data
);

  function automatic logic [CLIP_W-1:0] clip(input logic signed [POS_W-1:0] v, input int hi);
    logic [CLIP_W-1:0] res;
    if (v < 0)                           res = '0;
    else if (v > POS_W'(hi))             res = CLIP_W'(hi);
    else                                 res = CLIP_W'(v);
    return res;
  endfunction

  logic [DATA_W-1:0]        plane [DEPTH];
  logic [DATA_W-1:0]        rdata;
  logic [ADDR_W-1:0]        raddr, waddr, cell_addr, item_addr, clr_cnt;
  logic                     we;
  logic [DATA_W-1:0]        wdata;

  logic signed [DATA_W-1:0] g;
  logic [7:0]               prow, pcol;
  logic                     in_range;
  logic signed [POS_W-1:0]  r0_s, c0_s, r1_s, c1_s;
  logic [CLIP_W-1:0]        r0, r1, c0, c1, row, col;
  logic [AREA_W-1:0]        area, area_r;
  logic [AREA_W-1:0]        rem;
  logic [AREA_W:0]          rem_sh, rem_sub;
  logic                     ge;
  logic [DATA_W-1:0]        quo;
  logic                     neg;
  logic [DCNT_W-1:0]        dcnt;
  logic signed [DATA_W-1:0] q;
  logic signed [DATA_W:0]   sum;
  logic signed [DATA_W-1:0] sat;

  // window corners from stride and padding
  assign r0_s = $signed({2'b00, 13'(prow * cfg.stride_rows)})
              - $signed({11'd0, cfg.padding_top});
  assign c0_s = $signed({2'b00, 13'(pcol * cfg.stride_cols)})
              - $signed({11'd0, cfg.padding_left});
  assign r1_s = r0_s + $signed({10'd0, cfg.kernel_height});
  assign c1_s = c0_s + $signed({10'd0, cfg.kernel_width});

  assign area = cfg.include_padding ? AREA_W'(cfg.kernel_height * cfg.kernel_width)
                                    : AREA_W'((r1 - r0) * (c1 - c0));

  assign rem_sh  = {rem, quo[DATA_W-1]};
  assign ge      = rem_sh >= {1'b0, area_r};
  assign rem_sub = rem_sh - {1'b0, area_r};

  assign sum = {rdata[DATA_W-1], rdata} + {q[DATA_W-1], q};
  always_comb begin
    if (sum[DATA_W] != sum[DATA_W-1])
      sat = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    else
      sat = sum[DATA_W-1:0];
  end

  assign cell_addr = ADDR_W'(int'(row) * OUT_W + int'(col));
  assign item_addr = ADDR_W'(int'(read_row) * OUT_W + int'(read_col));
  assign raddr     = cmd.rd_item ? item_addr : cell_addr;
  assign we        = cmd.clr_wr || cmd.cell_wr;
  assign waddr     = cmd.clr_wr ? clr_cnt : cell_addr;
  assign wdata     = cmd.clr_wr ? '0 : sat;

  always_ff @(posedge clk) begin
    if (we) plane[waddr] <= wdata;
    if (cmd.rd_item || cmd.cell_rd) rdata <= plane[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr_wr) clr_cnt <= stat.clr_last ? '0 : clr_cnt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      g    <= grad_value;
      prow <= pooled_row;
      pcol <= pooled_col;
    end
    if (cmd.rd_item) in_range <= (int'(read_row) < OUT_H) && (int'(read_col) < OUT_W);
    if (cmd.win) begin
      r0 <= clip(r0_s, OUT_H);
      r1 <= clip(r1_s, OUT_H);
      c0 <= clip(c0_s, OUT_W);
      c1 <= clip(c1_s, OUT_W);
    end
    if (cmd.area) begin
      area_r <= area;
      quo    <= g[DATA_W-1] ? DATA_W'(-g) : DATA_W'(g);
      neg    <= g[DATA_W-1];
      rem    <= '0;
      dcnt   <= '0;
      row    <= r0;
      col    <= c0;
    end
    if (cmd.div_step) begin
      rem  <= ge ? rem_sub[AREA_W-1:0] : rem_sh[AREA_W-1:0];
      quo  <= {quo[DATA_W-2:0], ge};
      dcnt <= dcnt + 1'b1;
    end
    if (cmd.quot) q <= neg ? -$signed(quo) : $signed(quo);
    if (cmd.cell_wr) begin
      if (col == c1 - 1'b1) begin
        col <= c0;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
    if (cmd.out_load) out_data <= in_range ? $signed(rdata) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst)               out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready)    out_valid <= 1'b0;
  end

  assign stat.empty     = (r1 <= r0) || (c1 <= c0);
  assign stat.div_last  = dcnt == DCNT_W'(DATA_W - 1);
  assign stat.cell_last = (row == r1 - 1'b1) && (col == c1 - 1'b1);
  assign stat.clr_last  = clr_cnt == ADDR_W'(DEPTH - 1);
  assign stat.out_free  = !out_valid || out_ready;

endmodule

[rtl/avg_pool_backward_scatter.sv]
// channel   dir  handshake        payload
// item      in   valid/ready      opcode, grad_value, pooled_row/col, read_row/col
// result    out  valid/ready      read_value (one per read)
// apb       in   psel/penable     kernel, stride, padding, include_padding
//
// Read: the accept state, then ST_READ loads the result. Scatter: ST_WIN, ST_AREA,
// then ST_DIV (one quotient bit a cycle in the divider), ST_QUOT, then one plane RAM
// read then write per window cell. Clear: the accept cycle then one cell a cycle. After
// reset a clearing pass runs with item.ready low. A result stalled on the output holds
// only further reads.
module avg_pool_backward_scatter
  import avgpb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  avgpb_item_if.sink         item,
  avgpb_result_if.source     result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  avgpb_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  avgpb_ctrl u_ctrl (
    .clk, .rst,
    .item_valid  (item.valid),
    .item_opcode (item.opcode),
    .item_ready  (item.ready),
    .stat, .cmd
  );

  avgpb_dp u_dp (
    .clk, .rst, .cfg, .cmd, .stat,
    .grad_value (item.grad_value),
    .pooled_row (item.pooled_row),
    .pooled_col (item.pooled_col),
    .read_row   (item.read_row),
    .read_col   (item.read_col),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_data   (result.read_value)
  );

endmodule

[rtl/avgpb_checker.sv]
module avgpb_checker
  import avgpb_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic item_valid,
  input logic item_ready,
  input opcode_t item_opcode,
  input logic res_valid,
  input logic res_ready,
  input logic [DATA_W-1:0] res_value,
  input logic pready
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_value))
    else $error("stalled result beat dropped or changed");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

  a_reset_busy: assert property (@(posedge clk) rst |=> !item_ready)
    else $error("item taken during clearing pass");

  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready &&
    (item_opcode == OP_CLEAR || item_opcode == OP_SCATTER || item_opcode == OP_READ)
    |=> !item_ready)
    else $error("item taken while previous beat still in work");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (item_opcode == OP_READ) |=> ##1 res_valid)
    else $error("read beat gave no result");

endmodule

bind avg_pool_backward_scatter avgpb_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item.valid),
  .item_ready  (item.ready),
  .item_opcode (item.opcode),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_value   (result.read_value),
  .pready      (pready)
);

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import avgpb_pkg::*;

  localparam int CLK_HALF   = 4;
  localparam int SETTLE_CYC = 5000;
  localparam int CYC_LIMIT  = 20000000;
  localparam int HOLD_CYC   = 2500;

  typedef struct {
    opcode_t     opcode;
    logic [31:0] grad_value;
    logic [7:0]  pooled_row;
    logic [7:0]  pooled_col;
    logic [5:0]  read_row;
    logic [5:0]  read_col;
  } pool_item_t;

  localparam opcode_t OP_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  avgpb_item_if   item_bus ();
  avgpb_result_if res_bus ();

  avg_pool_backward_scatter i_dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_bus),
    .result  (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #CLK_HALF clk = ~clk;

  // shadow of the accumulator plane and the pooling settings
  int signed   plane_shadow [DEPTH];
  int unsigned kh, kw, sr, sc, pt, pl, incl;

  pool_item_t  pending_items [$];
  logic [31:0] expected_cells [$];
  pool_item_t  staged;
  int          error_count = 0;
  int          cyc = 0;
  logic        hold_sender = 1'b0;
  logic        hold_rx = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %08h want %08h at cycle %0d", what, got, want, cyc);
    error_count++;
  endtask

  function automatic longint clip(input longint v, input longint hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // apply one accepted item to the shadow plane, or queue the expected value of a read
  function automatic void apply_item(input pool_item_t it);
    longint g, r0, c0, r1, c1, area, q, s;
    if (it.opcode == OP_CLEAR) begin
      foreach (plane_shadow[i]) plane_shadow[i] = 0;
    end else if (it.opcode == OP_SCATTER) begin
      g  = longint'($signed(it.grad_value));
      r0 = longint'(it.pooled_row) * sr - pt;
      c0 = longint'(it.pooled_col) * sc - pl;
      r1 = clip(r0 + kh, OUT_H);
      c1 = clip(c0 + kw, OUT_W);
      r0 = clip(r0, OUT_H);
      c0 = clip(c0, OUT_W);
      if (r1 > r0 && c1 > c0) begin
        area = incl ? longint'(kh) * kw : (r1 - r0) * (c1 - c0);
        if (area > 0) begin
          q = g / area;
          for (longint r = r0; r < r1; r++) begin
            for (longint c = c0; c < c1; c++) begin
              s = longint'(plane_shadow[r * OUT_W + c]) + q;
              if (s > 64'sd2147483647) s = 64'sd2147483647;
              if (s < -64'sd2147483648) s = -64'sd2147483648;
              plane_shadow[r * OUT_W + c] = int'(s);
            end
          end
        end
      end
    end else if (it.opcode == OP_READ) begin
      if (it.read_row < OUT_H && it.read_col < OUT_W)
        expected_cells.push_back(plane_shadow[it.read_row * OUT_W + it.read_col]);
      else
        expected_cells.push_back(32'd0);
    end
  endfunction

  function automatic int gap_pct();
    return (cyc > 60000 && cyc < 110000) ? 0 : 6;
  endfunction

  // item driver
  always @(posedge clk) begin
    if (rst) begin
      item_bus.valid <= 1'b0;
    end else begin
      if (item_bus.valid && item_bus.ready) apply_item(staged);
      if (!item_bus.valid || item_bus.ready) begin
        if (pending_items.size() > 0 && !hold_sender && $urandom_range(99) >= gap_pct()) begin
          staged = pending_items.pop_front();
          item_bus.valid      <= 1'b1;
          item_bus.opcode     <= staged.opcode;
          item_bus.grad_value <= staged.grad_value;
          item_bus.pooled_row <= staged.pooled_row;
          item_bus.pooled_col <= staged.pooled_col;
          item_bus.read_row   <= staged.read_row;
          item_bus.read_col   <= staged.read_col;
        end else begin
          item_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver
  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (expected_cells.size() == 0)
          report("unexpected read_value", res_bus.read_value, 32'd0);
        else if (res_bus.read_value !== expected_cells[0]) begin
          report("read_value", res_bus.read_value, expected_cells[0]);
          void'(expected_cells.pop_front());
        end else
          void'(expected_cells.pop_front());
      end
      res_bus.ready <= !hold_rx && ($urandom_range(99) >= gap_pct());
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input int unsigned val);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= PADDR_W'(idx * 4);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_KH:   kh   = val & 5'h1f;
      REG_KW:   kw   = val & 5'h1f;
      REG_SR:   sr   = val & 5'h1f;
      REG_SC:   sc   = val & 5'h1f;
      REG_PT:   pt   = val & 4'hf;
      REG_PL:   pl   = val & 4'hf;
      REG_INCL: incl = val & 1'b1;
      default: ;
    endcase
  endtask

  task automatic set_pooling(input int unsigned h, w, srow, scol, ptop, pleft, inc);
    write_reg(REG_KH, h);
    write_reg(REG_KW, w);
    write_reg(REG_SR, srow);
    write_reg(REG_SC, scol);
    write_reg(REG_PT, ptop);
    write_reg(REG_PL, pleft);
    write_reg(REG_INCL, inc);
  endtask

  // wait until every item is taken and every read has come back
  task automatic drain();
    while (pending_items.size() > 0 || item_bus.valid || expected_cells.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic push(input opcode_t op, input logic [31:0] g,
                      input logic [7:0] pr, pc, input logic [5:0] rr, rc);
    pool_item_t it;
    it.opcode = op; it.grad_value = g; it.pooled_row = pr; it.pooled_col = pc;
    it.read_row = rr; it.read_col = rc;
    pending_items.push_back(it);
  endtask

  task automatic push_random(input int n, input int read_pct);
    pool_item_t it;
    int unsigned pick, hi_r, hi_c;
    repeat (n) begin
      pick = $urandom_range(99);
      it.opcode = pick < read_pct ? OP_READ : pick < 97 ? OP_SCATTER :
                  pick < 98 ? OP_CLEAR : OP_UNUSED;
      case ($urandom_range(3))
        0: it.grad_value = $urandom;
        1: it.grad_value = $urandom_range(1, 3) == 1 ? 32'h7fffffff : 32'h80000000;
        default: it.grad_value = $urandom_range(0, 32'h3ffff) - 32'h20000;
      endcase
      // keep most windows inside the plane
      hi_r = (OUT_H + pt) / (sr ? sr : 1);
      hi_c = (OUT_W + pl) / (sc ? sc : 1);
      if (hi_r > 255) hi_r = 255;
      if (hi_c > 255) hi_c = 255;
      it.pooled_row = $urandom_range(7) == 0 ? 8'($urandom) : 8'($urandom_range(hi_r));
      it.pooled_col = $urandom_range(7) == 0 ? 8'($urandom) : 8'($urandom_range(hi_c));
      it.read_row = 6'($urandom);
      it.read_col = 6'($urandom);
      pending_items.push_back(it);
    end
  endtask

  initial begin
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    item_bus.valid = 1'b0; item_bus.opcode = OP_CLEAR; item_bus.grad_value = '0;
    item_bus.pooled_row = '0; item_bus.pooled_col = '0;
    item_bus.read_row = '0; item_bus.read_col = '0;
    res_bus.ready = 1'b0;
    foreach (plane_shadow[i]) plane_shadow[i] = 0;
    kh = 2; kw = 2; sr = 2; sc = 2; pt = 0; pl = 0; incl = 1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: extremes of the fields
    push(OP_READ, 0, 0, 0, 6'd0, 6'd0);
    push(OP_SCATTER, 32'h7fffffff, 0, 0, 0, 0);
    push(OP_SCATTER, 32'h80000000, 0, 1, 0, 0);
    push(OP_SCATTER, 32'h1234, 8'd255, 8'd255, 0, 0);
    push(OP_SCATTER, 32'hfffffff9, 31, 31, 0, 0);
    push(OP_READ, 0, 0, 0, 6'd0, 6'd0);
    push(OP_READ, 0, 0, 0, 6'd1, 6'd3);
    push(OP_READ, 0, 0, 0, 6'd63, 6'd63);
    push(OP_UNUSED, 32'hffffffff, 8'hff, 8'hff, 6'h3f, 6'h3f);
    push(OP_READ, 0, 0, 0, 6'd62, 6'd62);
    push(OP_CLEAR, 0, 0, 0, 0, 0);
    push(OP_READ, 0, 0, 0, 6'd0, 6'd1);
    push_random(80, 40);
    drain();

    // unit window: saturation both ways
    set_pooling(1, 1, 1, 1, 0, 0, 1);
    push(OP_SCATTER, 32'h7fffffff, 5, 5, 0, 0);
    push(OP_SCATTER, 32'h7fffffff, 5, 5, 0, 0);
    push(OP_READ, 0, 0, 0, 6'd5, 6'd5);
    push(OP_SCATTER, 32'h80000000, 6, 6, 0, 0);
    push(OP_SCATTER, 32'h80000000, 6, 6, 0, 0);
    push(OP_READ, 0, 0, 0, 6'd6, 6'd6);
    push_random(60, 40);
    drain();

    // zero kernel and zero stride
    set_pooling(0, 3, 0, 0, 15, 15, 0);
    push(OP_SCATTER, 32'h10000, 0, 0, 0, 0);
    push(OP_READ, 0, 0, 0, 6'd0, 6'd0);
    push_random(20, 40);
    drain();
    set_pooling(16, 16, 0, 0, 15, 15, 0);
    push_random(40, 40);
    drain();

    // largest settings, only a few items
    set_pooling(31, 31, 31, 31, 15, 15, 0);
    push_random(15, 40);
    drain();
    set_pooling(16, 16, 16, 16, 15, 15, 1);
    push_random(30, 40);
    drain();

    // long receiver hold while reads pile up
    set_pooling(3, 3, 2, 2, 1, 1, 0);
    hold_rx <= 1'b1;
    push_random(100, 60);
    repeat (HOLD_CYC) @(posedge clk);
    hold_rx <= 1'b0;
    drain();

    repeat (4) begin
      set_pooling($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(0, 4),
                  $urandom_range(0, 4), $urandom_range(0, 15), $urandom_range(0, 15),
                  $urandom_range(1));
      push_random(40, 40);
      // pause the sender mid-stream until every pending read has returned
      repeat (300) @(posedge clk);
      hold_sender <= 1'b1;
      @(posedge clk);
      while (item_bus.valid || expected_cells.size() > 0)
        @(posedge clk);
      hold_sender <= 1'b0;
      drain();
    end

    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
